// ===== hw/rtl/m6502am_pkg.sv =====
// Shared types and constants for the 6502 addressing-mode unit.
`default_nettype none

package m6502am_pkg;

    // Access direction codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Addressing-mode codes
    localparam logic [2:0] MODE_ZP    = 3'd0;
    localparam logic [2:0] MODE_ZP_X  = 3'd1;
    localparam logic [2:0] MODE_ZP_Y  = 3'd2;
    localparam logic [2:0] MODE_ABS_X = 3'd3;
    localparam logic [2:0] MODE_ABS_Y = 3'd4;
    localparam logic [2:0] MODE_IND   = 3'd5;
    localparam logic [2:0] MODE_IND_X = 3'd6;
    localparam logic [2:0] MODE_IND_Y = 3'd7;

    // Request word
    typedef struct packed {
        logic        opcode;
        logic [2:0]  mode;
        logic [15:0] operand_address;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  write_byte;
    } req_t;

    // Response word
    typedef struct packed {
        logic [7:0]  read_byte;
        logic [15:0] effective_address;
        logic        bad_request;
    } rsp_t;

    // Memory address source
    typedef enum logic [1:0] {
        ADDR_PTR_LO,
        ADDR_PTR_HI,
        ADDR_EA_REG,
        ADDR_EA_PTR
    } addr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_req;
        addr_sel_t addr_sel;
        logic      mem_rd;
        logic      mem_wr;
        logic      load_plo;
        logic      load_ea;
        logic      load_rsp;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_indirect;
        logic req_write;
        logic req_bad;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/m6502am_ctrl.sv =====
// Sequencer for pointer fetches, data access and response handoff.
`default_nettype none

module m6502am_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    input  wire m6502am_pkg::stat_t stat,
    output m6502am_pkg::cmd_t       cmd
);
    import m6502am_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTR_LO,
        ST_PTR_HI,
        ST_PTR_EA,
        ST_ACCESS,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign rsp_valid = rsp_valid_reg;

    // Next state and command decode
    always_comb
    begin
        cmd            = '0;
        cmd.addr_sel   = ADDR_EA_REG;
        req_stall      = 1'b1;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = stat.in_indirect ? ST_PTR_LO : ST_ACCESS;
                end
            end
            ST_PTR_LO:
            begin
                cmd.addr_sel = ADDR_PTR_LO;
                cmd.mem_rd   = 1'b1;
                state_next   = ST_PTR_HI;
            end
            ST_PTR_HI:
            begin
                // read data now holds the pointer low byte
                cmd.addr_sel = ADDR_PTR_HI;
                cmd.mem_rd   = 1'b1;
                cmd.load_plo = 1'b1;
                state_next   = ST_PTR_EA;
            end
            ST_PTR_EA:
            begin
                // pointer complete: access data at the pointer target
                cmd.addr_sel = ADDR_EA_PTR;
                cmd.load_ea  = 1'b1;
                cmd.mem_rd   = !stat.req_write;
                cmd.mem_wr   = stat.req_write && !stat.req_bad;
                state_next   = ST_RESP;
            end
            ST_ACCESS:
            begin
                cmd.addr_sel = ADDR_EA_REG;
                cmd.mem_rd   = !stat.req_write;
                cmd.mem_wr   = stat.req_write && !stat.req_bad;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                // hand off the response and take the next request together
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    req_stall      = 1'b0;
                    if (req_valid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = stat.in_indirect ? ST_PTR_LO : ST_ACCESS;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/m6502am_dp.sv =====
// Address generation, byte memory and response register.
`default_nettype none

module m6502am_dp #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic              clk,
    input  wire m6502am_pkg::req_t req,
    input  wire m6502am_pkg::cmd_t cmd,
    output m6502am_pkg::stat_t     stat,
    output m6502am_pkg::rsp_t      rsp
);
    import m6502am_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    logic [7:0]           mem_array [MEM_DEPTH];
    req_t                 req_reg;
    logic [7:0]           plo_reg;
    logic [ADDR_BITS-1:0] ea_reg;
    logic [7:0]           rdata_reg;
    rsp_t                 rsp_reg;

    logic [7:0]           zp_in, zpx_in, zpy_in;
    logic [15:0]          dir_ea16;
    logic [7:0]           zp_held, zpx_held;
    logic [15:0]          plo_addr16, phi_addr16, ptr16;
    logic [ADDR_BITS-1:0] mem_addr;

    // Status for the controller
    always_comb
    begin
        stat.in_indirect = req.mode inside {MODE_IND, MODE_IND_X, MODE_IND_Y};
        stat.req_write   = (req_reg.opcode == OP_WRITE);
        stat.req_bad     = (req_reg.opcode == OP_WRITE) && (req_reg.mode == MODE_IND);
    end

    // Direct-mode address from the incoming word; 8-bit sums wrap in page zero
    always_comb
    begin
        zp_in  = req.operand_address[7:0];
        zpx_in = zp_in + req.index_x;
        zpy_in = zp_in + req.index_y;
        case (req.mode)
            MODE_ZP:    dir_ea16 = {8'h00, zp_in};
            MODE_ZP_X:  dir_ea16 = {8'h00, zpx_in};
            MODE_ZP_Y:  dir_ea16 = {8'h00, zpy_in};
            MODE_ABS_X: dir_ea16 = req.operand_address + {8'h00, req.index_x};
            MODE_ABS_Y: dir_ea16 = req.operand_address + {8'h00, req.index_y};
            default:    dir_ea16 = req.operand_address;
        endcase
    end

    // Pointer byte addresses; plain indirect crosses pages, zero-page ones wrap
    always_comb
    begin
        zp_held  = req_reg.operand_address[7:0];
        zpx_held = zp_held + req_reg.index_x;
        case (req_reg.mode)
            MODE_IND:
            begin
                plo_addr16 = req_reg.operand_address;
                phi_addr16 = req_reg.operand_address + 16'd1;
            end
            MODE_IND_X:
            begin
                plo_addr16 = {8'h00, zpx_held};
                phi_addr16 = {8'h00, 8'(zpx_held + 8'd1)};
            end
            default:
            begin
                plo_addr16 = {8'h00, zp_held};
                phi_addr16 = {8'h00, 8'(zp_held + 8'd1)};
            end
        endcase
    end

    // Pointer target, with Y added for indirect-indexed
    always_comb
    begin
        if (req_reg.mode == MODE_IND_Y)
            ptr16 = {rdata_reg, plo_reg} + {8'h00, req_reg.index_y};
        else
            ptr16 = {rdata_reg, plo_reg};
    end

    // Memory address select
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_PTR_LO: mem_addr = plo_addr16[ADDR_BITS-1:0];
            ADDR_PTR_HI: mem_addr = phi_addr16[ADDR_BITS-1:0];
            ADDR_EA_PTR: mem_addr = ptr16[ADDR_BITS-1:0];
            default:     mem_addr = ea_reg;
        endcase
    end

    // Single-port byte memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem_array[mem_addr] <= req_reg.write_byte;
        if (cmd.mem_rd)
            rdata_reg <= mem_array[mem_addr];
    end

    // Request, pointer and address registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
            ea_reg  <= dir_ea16[ADDR_BITS-1:0];
        end
        else if (cmd.load_ea)
        begin
            ea_reg <= ptr16[ADDR_BITS-1:0];
        end
        if (cmd.load_plo)
            plo_reg <= rdata_reg;
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.read_byte         <= stat.req_write ? 8'h00 : rdata_reg;
            rsp_reg.effective_address <= 16'(ea_reg);
            rsp_reg.bad_request       <= stat.req_bad;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mos6502_addressing_mode_unit.sv =====
// Zero-page and absolute modes go from request accept through the access state to the
// response state; the three indirect modes go through pointer low fetch, pointer high
// fetch and pointer-target data access on the single-port memory. A new word is taken
// only in idle or as the last response is handed off, and a stalled response holds it back.
// Reset clears the sequencer and response valid; memory contents stay undefined
// until written and no clearing pass runs.
`default_nettype none

module mos6502_addressing_mode_unit #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire m6502am_pkg::req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output m6502am_pkg::rsp_t      rsp
);
    import m6502am_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    m6502am_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    m6502am_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk  (clk),
        .req  (req),
        .cmd  (cmd),
        .stat (stat),
        .rsp  (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/m6502am_chk.sv =====
// Port-level checker for the addressing-mode unit, with its bind.
`default_nettype none

module m6502am_chk #(
    parameter int ADDR_BITS = 16
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire m6502am_pkg::req_t req,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire m6502am_pkg::rsp_t rsp
);
    import m6502am_pkg::*;

    // A held response stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A held response word does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response word changed while stalled");

    // Every word needs a memory access before the next accept: no back-to-back accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted in consecutive cycles");

    // Rejected indirect writes return a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.bad_request |-> rsp.read_byte == 8'h00)
        else $error("bad request carries read data");

    // Effective address stays inside the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.effective_address >> ADDR_BITS) == 16'h0000)
        else $error("effective address beyond memory size");

endmodule

bind mos6502_addressing_mode_unit m6502am_chk #(
    .ADDR_BITS (ADDR_BITS)
) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
